FILE: rtl/core/jsu_pkg.sv
// Shared types, constants and helpers for the JSON string unescaper.
// No dependencies.
`default_nettype none
package jsu_pkg;

	localparam int QDEPTH_DEF = 4;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_U     = 8'h75;

	localparam logic [15:0] SURR_LO  = 16'hD800;
	localparam logic [15:0] SURR_HI  = 16'hDFFF;
	localparam logic [15:0] LIM_1B   = 16'h0080;
	localparam logic [15:0] LIM_2B   = 16'h0800;
	localparam logic [7:0]  LEAD_2B  = 8'hC0;
	localparam logic [7:0]  LEAD_3B  = 8'hE0;
	localparam logic [7:0]  CONT_B   = 8'h80;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_CLOSED = 2'd1,
		ST_CUT    = 2'd2
	} end_status_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_STR  = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	// one decoded step: up to three bytes and a string end status
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
		end_status_t     status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.is_hex = 1'b1;
		h.val    = 4'd0;
		if (c >= 8'h30 && c <= 8'h39)
			h.val = c[3:0];
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			h.val = c[3:0] + 4'd9;
		else
			h.is_hex = 1'b0;
		return h;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/jsu_in_if.sv
// Input word channel: raw text byte and end-of-text flag.
// No dependencies.
`default_nettype none
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, in_byte, end_of_text, input ready);
	modport sink (input valid, in_byte, end_of_text, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/jsu_out_if.sv
// Output word channel: decoded byte with status and last marker.
// No dependencies.
`default_nettype none
interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [1:0] end_status;
	logic       last;

	modport source (output valid, out_byte, byte_valid, end_status, last, input ready);
	modport sink (input valid, out_byte, byte_valid, end_status, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/json_string_unescape.sv
// Streaming JSON string unescaper, top level: front end, command queue, back end.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_queue, jsu_back.
//
// One text byte is taken per cycle while the command queue has room; each byte
// turns into zero to three result words, and the back end hands out one result
// word per cycle from the queue head while tx is ready. A \u escape's fourth
// character yields up to three words; the QDEPTH-entry queue lets the front run
// ahead over the bytes that produce nothing, so with tx ready the sustained rate
// is one byte per cycle on ordinary text; results are registered in the queue.
`default_nettype none
module json_string_unescape #(
	parameter int QDEPTH = jsu_pkg::QDEPTH_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	jsu_in_if.sink    rx,
	jsu_out_if.source tx
);
	jsu_pkg::cmd_t    cmd, head;
	jsu_pkg::q_stat_t qstat;
	logic             push, pop;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.qstat  (qstat),
		.push   (push),
		.cmd    (cmd)
	);

	jsu_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.pop    (pop),
		.head   (head),
		.stat   (qstat)
	);

	jsu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.tx     (tx)
	);

	a_status_word_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && !tx.byte_valid |-> tx.last && tx.end_status != jsu_pkg::ST_NONE)
		else $error("status-only word not marked last");

	a_empty_no_valid: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> !tx.valid)
		else $error("output valid with empty queue");

	a_pop_clears_full: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full && pop && !push |=> !qstat.full)
		else $error("queue still full after pop");
endmodule
`default_nettype wire

FILE: rtl/core/jsu_front.sv
// Front end: takes text bytes, tracks string/escape state, builds commands.
// Depends on jsu_pkg, jsu_in_if.
`default_nettype none
module jsu_front (
	input  wire              clk,
	input  wire              arst_n,
	jsu_in_if.sink           rx,
	input  jsu_pkg::q_stat_t qstat,
	output logic             push,
	output jsu_pkg::cmd_t    cmd
);
	jsu_pkg::mode_t mode_q, mode_d;
	logic [1:0]     hex_count_q, hex_count_d;
	logic [15:0]    hex_value_q, hex_value_d;
	logic           hex_stopped_q, hex_stopped_d;

	logic [7:0]     c;
	logic           acc;
	logic           ignored;
	logic           closing;
	jsu_pkg::hex_t  hd;
	logic [15:0]    hex_upd;
	logic           stop_upd;
	logic [15:0]    cp;

	assign c       = rx.in_byte;
	assign rx.ready = !qstat.full;
	assign acc     = rx.valid && rx.ready;
	assign hd      = jsu_pkg::hex_digit(c);
	assign ignored = (mode_q == jsu_pkg::MODE_IDLE) && (c != jsu_pkg::CH_QUOTE);
	assign closing = (mode_q == jsu_pkg::MODE_STR) && (c == jsu_pkg::CH_QUOTE);

	always_comb begin
		hex_upd  = hex_value_q;
		stop_upd = hex_stopped_q;
		if (!hd.is_hex)
			stop_upd = 1'b1;
		else if (!hex_stopped_q)
			hex_upd = {hex_value_q[11:0], hd.val};
	end

	// next state
	always_comb begin
		mode_d        = mode_q;
		hex_count_d   = hex_count_q;
		hex_value_d   = hex_value_q;
		hex_stopped_d = hex_stopped_q;
		case (mode_q)
			jsu_pkg::MODE_IDLE: begin
				if (c == jsu_pkg::CH_QUOTE)
					mode_d = jsu_pkg::MODE_STR;
			end
			jsu_pkg::MODE_STR: begin
				if (c == jsu_pkg::CH_QUOTE)
					mode_d = jsu_pkg::MODE_IDLE;
				else if (c == jsu_pkg::CH_BSL)
					mode_d = jsu_pkg::MODE_ESC;
			end
			jsu_pkg::MODE_ESC: begin
				mode_d = jsu_pkg::MODE_STR;
				if (c == jsu_pkg::CH_U) begin
					mode_d        = jsu_pkg::MODE_HEX;
					hex_count_d   = 2'd0;
					hex_value_d   = 16'd0;
					hex_stopped_d = 1'b0;
				end
			end
			jsu_pkg::MODE_HEX: begin
				if (hex_count_q == 2'd3) begin
					mode_d        = jsu_pkg::MODE_STR;
					hex_count_d   = 2'd0;
					hex_value_d   = 16'd0;
					hex_stopped_d = 1'b0;
				end else begin
					hex_count_d   = hex_count_q + 2'd1;
					hex_value_d   = hex_upd;
					hex_stopped_d = stop_upd;
				end
			end
			default: mode_d = jsu_pkg::MODE_IDLE;
		endcase
		if (!ignored && !closing && rx.end_of_text) begin
			mode_d        = jsu_pkg::MODE_IDLE;
			hex_count_d   = 2'd0;
			hex_value_d   = 16'd0;
			hex_stopped_d = 1'b0;
		end
	end

	// outputs
	always_comb begin
		cp = hex_upd;
		if (cp >= jsu_pkg::SURR_LO && cp <= jsu_pkg::SURR_HI)
			cp = {8'd0, jsu_pkg::CH_QMARK};
		cmd.bytes  = '0;
		cmd.cnt    = 2'd0;
		cmd.status = jsu_pkg::ST_NONE;
		case (mode_q)
			jsu_pkg::MODE_STR: begin
				if (c != jsu_pkg::CH_QUOTE && c != jsu_pkg::CH_BSL) begin
					cmd.bytes[0] = c;
					cmd.cnt      = 2'd1;
				end
			end
			jsu_pkg::MODE_ESC: begin
				if (c == jsu_pkg::CH_N || c == jsu_pkg::CH_T) begin
					cmd.bytes[0] = jsu_pkg::CH_SPACE;
					cmd.cnt      = 2'd1;
				end else if (c != jsu_pkg::CH_R && c != jsu_pkg::CH_B &&
					     c != jsu_pkg::CH_F && c != jsu_pkg::CH_U) begin
					cmd.bytes[0] = c;
					cmd.cnt      = 2'd1;
				end
			end
			jsu_pkg::MODE_HEX: begin
				if (hex_count_q == 2'd3) begin
					if (cp < jsu_pkg::LIM_1B) begin
						cmd.bytes[0] = cp[7:0];
						cmd.cnt      = 2'd1;
					end else if (cp < jsu_pkg::LIM_2B) begin
						cmd.bytes[0] = jsu_pkg::LEAD_2B | {3'd0, cp[10:6]};
						cmd.bytes[1] = jsu_pkg::CONT_B | {2'd0, cp[5:0]};
						cmd.cnt      = 2'd2;
					end else begin
						cmd.bytes[0] = jsu_pkg::LEAD_3B | {4'd0, cp[15:12]};
						cmd.bytes[1] = jsu_pkg::CONT_B | {2'd0, cp[11:6]};
						cmd.bytes[2] = jsu_pkg::CONT_B | {2'd0, cp[5:0]};
						cmd.cnt      = 2'd3;
					end
				end
			end
			default: cmd.cnt = 2'd0;
		endcase
		if (closing)
			cmd.status = jsu_pkg::ST_CLOSED;
		else if (!ignored && rx.end_of_text)
			cmd.status = jsu_pkg::ST_CUT;
		push = acc && (cmd.cnt != 2'd0 || cmd.status != jsu_pkg::ST_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= jsu_pkg::MODE_IDLE;
			hex_count_q   <= 2'd0;
			hex_value_q   <= 16'd0;
			hex_stopped_q <= 1'b0;
		end else if (acc) begin
			mode_q        <= mode_d;
			hex_count_q   <= hex_count_d;
			hex_value_q   <= hex_value_d;
			hex_stopped_q <= hex_stopped_d;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/jsu_queue.sv
// Command queue between front and back end, register based.
// Depends on jsu_pkg.
`default_nettype none
module jsu_queue #(
	parameter int DEPTH = jsu_pkg::QDEPTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  jsu_pkg::cmd_t    wdata,
	input  wire              pop,
	output jsu_pkg::cmd_t    head,
	output jsu_pkg::q_stat_t stat
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/jsu_back.sv
// Back end: expands the head command into result words, one per cycle while tx is ready.
// Depends on jsu_pkg, jsu_out_if.
`default_nettype none
module jsu_back (
	input  wire              clk,
	input  wire              arst_n,
	input  jsu_pkg::cmd_t    head,
	input  jsu_pkg::q_stat_t qstat,
	output logic             pop,
	jsu_out_if.source        tx
);
	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       is_last;
	logic       fire;

	assign last_idx = (head.cnt == 2'd0) ? 2'd0 : head.cnt - 2'd1;
	assign is_last  = (idx_q == last_idx);
	assign fire     = tx.valid && tx.ready;
	assign pop      = fire && is_last;

	assign tx.valid      = !qstat.empty;
	assign tx.byte_valid = (head.cnt != 2'd0);
	assign tx.out_byte   = (head.cnt != 2'd0) ? head.bytes[idx_q] : 8'd0;
	assign tx.last       = is_last;
	assign tx.end_status = is_last ? head.status : jsu_pkg::ST_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= 2'd0;
		else if (fire)
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
	end
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for json_string_unescape: feeds raw text words and
// checks every decoded result word against an in-bench streaming decoder.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and the json_string_unescape RTL.
module tb;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0]           data;
		logic                 bvalid;
		jsu_pkg::end_status_t status;
		logic                 lst;
	} result_word_t;

	logic clk;
	logic arst_n;

	jsu_in_if  rx ();
	jsu_out_if tx ();

	json_string_unescape u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.tx     (tx)
	);

	// decoder state
	jsu_pkg::mode_t dec_mode = jsu_pkg::MODE_IDLE;
	logic [1:0]     hex_seen = 2'd0;
	logic [15:0]    hex_acc  = 16'd0;
	logic           hex_halt = 1'b0;

	result_word_t expected_words[$];

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int holds_asked  = 0;
	int holds_done   = 0;
	int hold_left    = 0;
	int errors       = 0;
	int words_checked = 0;
	int bytes_sent   = 0;
	int strings_sent = 0;
	int cycle_cnt    = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timeout after %0d cycles", CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b1, 4'(c - "0")};
		if (c >= "a" && c <= "f")
			return {1'b1, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F")
			return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'd0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
		if (nib < 4'd10)
			return 8'("0") + 8'(nib);
		return (upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
	endfunction

	function automatic void clear_hex();
		hex_seen = 2'd0;
		hex_acc  = 16'd0;
		hex_halt = 1'b0;
	endfunction

	// one accepted text word -> zero to three expected result words
	task automatic unescape_byte(input logic [7:0] c, input logic eot);
		logic [7:0]           outb[$];
		jsu_pkg::end_status_t st;
		logic [4:0]           nib;
		logic [15:0]          cp;
		result_word_t         w;
		st = jsu_pkg::ST_NONE;
		case (dec_mode)
		jsu_pkg::MODE_IDLE: begin
			if (c != jsu_pkg::CH_QUOTE)
				return;
			dec_mode = jsu_pkg::MODE_STR;
		end
		jsu_pkg::MODE_STR: begin
			if (c == jsu_pkg::CH_QUOTE) begin
				dec_mode = jsu_pkg::MODE_IDLE;
				st = jsu_pkg::ST_CLOSED;
			end else if (c == jsu_pkg::CH_BSL) begin
				dec_mode = jsu_pkg::MODE_ESC;
			end else begin
				outb = {outb, c};
			end
		end
		jsu_pkg::MODE_ESC: begin
			dec_mode = jsu_pkg::MODE_STR;
			if (c == jsu_pkg::CH_N || c == jsu_pkg::CH_T) begin
				outb = {outb, jsu_pkg::CH_SPACE};
			end else if (c == jsu_pkg::CH_U) begin
				dec_mode = jsu_pkg::MODE_HEX;
				clear_hex();
			end else if (c != jsu_pkg::CH_R && c != jsu_pkg::CH_B &&
				     c != jsu_pkg::CH_F) begin
				outb = {outb, c};
			end
		end
		jsu_pkg::MODE_HEX: begin
			nib = hex_nibble(c);
			if (!nib[4])
				hex_halt = 1'b1;
			else if (!hex_halt)
				hex_acc = {hex_acc[11:0], nib[3:0]};
			if (hex_seen == 2'd3) begin
				cp = hex_acc;
				if (cp >= jsu_pkg::SURR_LO && cp <= jsu_pkg::SURR_HI)
					cp = {8'h00, jsu_pkg::CH_QMARK};
				if (cp < jsu_pkg::LIM_1B) begin
					outb = {outb, cp[7:0]};
				end else if (cp < jsu_pkg::LIM_2B) begin
					outb = {outb, jsu_pkg::LEAD_2B | {3'b000, cp[10:6]}};
					outb = {outb, jsu_pkg::CONT_B | {2'b00, cp[5:0]}};
				end else begin
					outb = {outb, jsu_pkg::LEAD_3B | {4'h0, cp[15:12]}};
					outb = {outb, jsu_pkg::CONT_B | {2'b00, cp[11:6]}};
					outb = {outb, jsu_pkg::CONT_B | {2'b00, cp[5:0]}};
				end
				clear_hex();
				dec_mode = jsu_pkg::MODE_STR;
			end else begin
				hex_seen = hex_seen + 2'd1;
			end
		end
		default: dec_mode = jsu_pkg::MODE_IDLE;
		endcase
		if (st == jsu_pkg::ST_NONE && eot) begin
			st = jsu_pkg::ST_CUT;
			dec_mode = jsu_pkg::MODE_IDLE;
			clear_hex();
		end
		for (int i = 0; i < outb.size(); i++) begin
			w.data   = outb[i];
			w.bvalid = 1'b1;
			w.status = (i == outb.size() - 1) ? st : jsu_pkg::ST_NONE;
			w.lst    = (i == outb.size() - 1);
			expected_words = {expected_words, w};
		end
		if (outb.size() == 0 && st != jsu_pkg::ST_NONE) begin
			w.data   = 8'h00;
			w.bvalid = 1'b0;
			w.status = st;
			w.lst    = 1'b1;
			expected_words = {expected_words, w};
		end
	endtask

	task automatic send_word(input logic [7:0] b, input logic eot);
		while ($urandom_range(99) < src_idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid       <= 1'b1;
		rx.in_byte     <= b;
		rx.end_of_text <= eot;
		do
			@(posedge clk);
		while (!rx.ready);
		bytes_sent++;
		unescape_byte(b, eot);
	endtask

	task automatic send_chars(input string s, input bit eot_on_last);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], eot_on_last && i == s.len() - 1);
	endtask

	task automatic wait_drained();
		rx.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_unicode(ref logic [7:0] txt[$]);
		logic [15:0] cp;
		logic [7:0]  ch;
		case ($urandom_range(4))
		0: cp = 16'($urandom_range(16'h007F));
		1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
		2: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
		3: cp = 16'($urandom_range(jsu_pkg::SURR_HI, jsu_pkg::SURR_LO));
		default: begin
			case ($urandom_range(7))
			0: cp = 16'h0000;
			1: cp = 16'h007F;
			2: cp = 16'h0080;
			3: cp = 16'h07FF;
			4: cp = 16'h0800;
			5: cp = 16'hD7FF;
			6: cp = 16'hE000;
			default: cp = 16'hFFFF;
			endcase
		end
		endcase
		txt = {txt, jsu_pkg::CH_BSL};
		txt = {txt, jsu_pkg::CH_U};
		for (int i = 3; i >= 0; i--) begin
			ch = hex_char(cp[i*4 +: 4], $urandom_range(1));
			if ($urandom_range(99) < 12)
				ch = 8'($urandom_range(255));
			txt = {txt, ch};
		end
	endtask

	// noise that may end the text, or noise then a quoted string that is closed or cut by end of text
	task automatic send_random_string();
		logic [7:0] txt[$];
		logic [7:0] b;
		int eot_at;
		int r;
		eot_at = -1;
		repeat ($urandom_range(2)) begin
			do
				b = 8'($urandom_range(255));
			while (b == jsu_pkg::CH_QUOTE);
			txt = {txt, b};
		end
		if (txt.size() != 0 && $urandom_range(9) == 0)
			eot_at = txt.size() - 1;
		if (eot_at < 0) begin
			txt = {txt, jsu_pkg::CH_QUOTE};
			repeat ($urandom_range(6, 1)) begin
				case ($urandom_range(3))
				0, 1: begin
					do
						b = 8'($urandom_range(255));
					while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL);
					txt = {txt, b};
				end
				2: begin
					txt = {txt, jsu_pkg::CH_BSL};
					case ($urandom_range(5))
					0: txt = {txt, jsu_pkg::CH_N};
					1: txt = {txt, jsu_pkg::CH_T};
					2: txt = {txt, jsu_pkg::CH_R};
					3: txt = {txt, jsu_pkg::CH_B};
					4: txt = {txt, jsu_pkg::CH_F};
					default: txt = {txt, 8'($urandom_range(255))};
					endcase
				end
				default: add_unicode(txt);
				endcase
			end
			r = $urandom_range(99);
			if (r < 70) begin
				txt = {txt, jsu_pkg::CH_QUOTE};
				if ($urandom_range(4) == 0)
					eot_at = txt.size() - 1;
			end else if (r < 85) begin
				eot_at = txt.size() - 1;
			end else begin
				eot_at = $urandom_range(txt.size() - 1, 1);
			end
		end
		for (int i = 0; i < txt.size() && (eot_at < 0 || i <= eot_at); i++)
			send_word(txt[i], i == eot_at);
		strings_sent++;
	endtask

	task automatic test_directed();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		send_chars("x", 1'b1);
		send_chars("\"", 1'b1);
		send_chars("\"", 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_chars("\\n\\r\\\"", 1'b0);
		send_chars("\\uDfFf\\uFFFF\"", 1'b0);
		wait_drained();
	endtask

	task automatic test_random(input int src_pct, input int snk_pct, input int n_words);
		int stop_at;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		stop_at = bytes_sent + n_words;
		while (bytes_sent < stop_at)
			send_random_string();
		wait_drained();
	endtask

	// output held off while the input keeps coming: queue fills, input stalls
	task automatic test_output_hold();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		holds_asked++;
		send_chars("\"abcdefgh", 1'b0);
		repeat (4) send_chars("\\u20AC", 1'b0);
		send_chars("\\u07ff\"", 1'b0);
		wait_drained();
	endtask

	// result side: check each accepted word, then drive ready
	initial begin
		result_word_t exp_w;
		tx.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && tx.valid && tx.ready) begin
				words_checked++;
				if (expected_words.size() == 0) begin
					$error("unexpected result word: out_byte %02h end_status %0d",
						tx.out_byte, tx.end_status);
					errors++;
				end else begin
					exp_w = expected_words.pop_front();
					if (tx.out_byte !== exp_w.data) begin
						$error("out_byte: expected %02h, got %02h", exp_w.data, tx.out_byte);
						errors++;
					end
					if (tx.byte_valid !== exp_w.bvalid) begin
						$error("byte_valid: expected %0b, got %0b", exp_w.bvalid, tx.byte_valid);
						errors++;
					end
					if (tx.end_status !== exp_w.status) begin
						$error("end_status: expected %0d, got %0d", exp_w.status, tx.end_status);
						errors++;
					end
					if (tx.last !== exp_w.lst) begin
						$error("last: expected %0b, got %0b", exp_w.lst, tx.last);
						errors++;
					end
				end
			end
			if (holds_done != holds_asked) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				tx.ready <= 1'b0;
			end else begin
				tx.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		rx.valid       <= 1'b0;
		rx.in_byte     <= 8'h00;
		rx.end_of_text <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(23, 67, 35);
		test_output_hold();
		test_random(67, 23, 35);
		test_random(0, 0, 35);

		wait_drained();
		$display("Sent %0d text words in %0d random strings plus directed cases; %0d results checked",
			bytes_sent, strings_sent, words_checked);
		$display("Idle mixes 23/67, 67/23 and none, one long output hold-off, drain pauses");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
